// File: rtl/lkf_pkg.sv
// ----------------------------------------------------------------------------
// lkf_pkg
// Shared types, constants and kernel tables for the 3x3 luma kernel filter.
// ----------------------------------------------------------------------------
package lkf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_FILTER_MODE  = 2'd2
    } lkf_reg_t;

    localparam logic [1:0] MODE_SHARPEN   = 2'd0;
    localparam logic [1:0] MODE_LAPLACIAN = 2'd1;
    localparam logic [1:0] MODE_SOBEL     = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // Luma weights (Q2.14), chroma and rebuild coefficients
    localparam int CY_R = 3483;
    localparam int CY_G = 11718;
    localparam int CY_B = 1183;
    localparam int CU_R = -1637;
    localparam int CU_G = -5505;
    localparam int CU_B = 7143;
    localparam int CV_R = 10076;
    localparam int CV_G = -9152;
    localparam int CV_B = -922;
    localparam int C_RV = 20976;
    localparam int C_GU = 3519;
    localparam int C_GV = 6234;
    localparam int C_BU = 34864;
    localparam int C_TENTH = 1638;

    localparam int QDEPTH = 4;

    localparam logic signed [5:0] KERN_SHARP [9] = '{-6'sd1, -6'sd2, -6'sd1,
                                                    -6'sd2, 6'sd22, -6'sd2,
                                                    -6'sd1, -6'sd2, -6'sd1};
    localparam logic signed [5:0] KERN_LAP   [9] = '{-6'sd1, -6'sd1, -6'sd1,
                                                    -6'sd1, 6'sd8, -6'sd1,
                                                    -6'sd1, -6'sd1, -6'sd1};
    localparam logic signed [5:0] KERN_SOBEL [9] = '{-6'sd2, -6'sd2, 6'sd0,
                                                    -6'sd2, 6'sd0, 6'sd2,
                                                    6'sd0, 6'sd2, 6'sd2};

    // One job handed from front to back: masked window, mode, centre pixel, frame-last flag
    typedef struct packed {
        logic [8:0][15:0] win;
        logic [1:0]       mode;
        logic [31:0]      pix;
        logic             last;
    } lkf_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lkf_qstat_t;

endpackage

// File: rtl/lkf_ram.sv
// ----------------------------------------------------------------------------
// lkf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lkf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/lkf_queue.sv
// ----------------------------------------------------------------------------
// lkf_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module lkf_queue
    import lkf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lkf_job_t   push_job,
    input  logic       pop,
    output lkf_job_t   head,
    output lkf_qstat_t stat
);

    localparam int PW = $clog2(QDEPTH);

    lkf_job_t        slot_reg [QDEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [PW:0]     cnt_reg, cnt_next;

    assign head       = slot_reg[rd_reg];
    assign stat.full  = (cnt_reg == (PW+1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && !stat.empty))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop && !stat.empty)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop && !stat.empty)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/lkf_front.sv
// ----------------------------------------------------------------------------
// lkf_front
// Accepts words, tracks stream position, keeps line buffers and the window.
// ----------------------------------------------------------------------------
module lkf_front
    import lkf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,
    input  logic                  s_tuser,
    input  lkf_qstat_t            qstat,
    output logic                  push,
    output lkf_job_t              push_job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT + 3);
    localparam int PW = $clog2(MAX_WIDTH + 3);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_EXEC = 3'b100
    } fstate_t;

    fstate_t         state_reg, state_next;
    logic [10:0]     width_reg;
    logic [12:0]     height_reg;
    logic [1:0]      mode_reg;
    logic [CW-1:0]   col_reg;
    logic [RW-1:0]   row_reg;
    logic [PW-1:0]   pend_reg;
    logic            kind_reg, second_reg;
    logic [31:0]     pix_reg, hold_reg;
    logic [15:0]     y_reg;
    logic [15:0]     win_reg [9];
    logic [15:0]     win_new [9];

    logic [WW-1:0]   w_eff;
    logic [RW-1:0]   h_eff;
    logic [CW-1:0]   ic, cc;
    logic [WW-1:0]   ic1;
    logic [RW-1:0]   crp;
    logic            res_valid, res_last, ok_top, ok_bot, ok_left, ok_right;
    logic            accept, pos_clear, adv_ok;
    logic            ram_we;
    logic [63:0]     ram_wdata, ram_rdata;
    logic [21:0]     y_sum;
    logic [8:0]      mask;

    // effective frame size, out-of-range values clamped
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);
        if (height_reg == '0)
            h_eff = RW'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(height_reg);
    end

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == F_IDLE) && !qstat.full;
    assign adv_ok   = (row_reg >= h_eff) && (pend_reg != '0);
    assign pos_clear = (s_tuser == KIND_PIXEL) && (row_reg >= h_eff);

    assign y_sum = 22'(CY_R * int'(pix_reg[7:0]) + CY_G * int'(pix_reg[15:8])
                       + CY_B * int'(pix_reg[23:16]));

    // position of the window centre (row offset by two)
    always_comb
    begin
        ic  = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        crp = (ic == '0) ? row_reg : row_reg + 1'b1;
        cc  = (ic == '0) ? CW'(w_eff - 1'b1) : ic - 1'b1;
        ic1 = {1'b0, ic} + 1'b1;
        res_valid = (crp >= RW'(2)) && (crp < h_eff + RW'(2));
        res_last  = (crp == h_eff + RW'(1)) && ({1'b0, cc} == w_eff - 1'b1);
        ok_top    = (crp >= RW'(3));
        ok_bot    = (crp < h_eff + RW'(1));
        ok_left   = (cc != '0);
        ok_right  = ({1'b0, cc} + 1'b1 < w_eff);
        mask = {ok_bot & ok_right, ok_bot, ok_bot & ok_left,
                ok_right, 1'b1, ok_left,
                ok_top & ok_right, ok_top, ok_top & ok_left};
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_new[r*3]     = win_reg[r*3+1];
            win_new[r*3+1]   = win_reg[r*3+2];
        end
        win_new[2] = ram_rdata[15:0];
        win_new[5] = ram_rdata[31:16];
        win_new[8] = y_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            push_job.win[i] = mask[i] ? ((ic == '0) ? win_reg[i] : win_new[i]) : 16'd0;
        end
        push_job.mode = mode_reg;
        push_job.pix  = hold_reg;
        push_job.last = res_last;
    end

    assign push      = (state_reg == F_EXEC) && res_valid;
    assign ram_we    = (state_reg == F_EXEC);
    assign ram_wdata = {pix_reg, y_reg, ram_rdata[31:16]};

    lkf_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ic),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && (s_tuser == KIND_PIXEL || adv_ok))
                    state_next = F_READ;
            end
            F_READ:
                state_next = F_EXEC;
            F_EXEC:
            begin
                if (!res_valid && kind_reg == KIND_FLUSH && !second_reg)
                    state_next = F_READ;
                else
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            mode_reg   <= MODE_SHARPEN;
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
            second_reg <= 1'b0;
            kind_reg   <= KIND_PIXEL;
            hold_reg   <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data[10:0];
                        col_reg <= '0;
                        row_reg <= '0;
                        pend_reg <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg <= '0;
                        row_reg <= '0;
                        pend_reg <= '0;
                    end
                    REG_FILTER_MODE:
                        mode_reg <= cfg_data[1:0];
                    default:
                        mode_reg <= mode_reg;
                endcase
            end
            else if (state_reg == F_IDLE && accept)
            begin
                kind_reg   <= s_tuser;
                second_reg <= 1'b0;
                if (s_tuser == KIND_PIXEL)
                begin
                    if (pos_clear)
                    begin
                        col_reg  <= '0;
                        row_reg  <= '0;
                        pend_reg <= PW'(1);
                    end
                    else
                        pend_reg <= pend_reg + 1'b1;
                end
            end
            else if (state_reg == F_EXEC)
            begin
                second_reg <= 1'b1;
                hold_reg   <= ram_rdata[63:32];
                for (int i = 0; i < 9; i++)
                    win_reg[i] <= win_new[i];
                if (res_valid && res_last)
                begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    pend_reg <= '0;
                end
                else
                begin
                    if (ic1 >= w_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                        col_reg <= ic1[CW-1:0];
                    if (res_valid && pend_reg != '0)
                        pend_reg <= pend_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && accept)
            pix_reg <= (s_tuser == KIND_PIXEL) ? s_tdata : 32'd0;
        else if (state_reg == F_EXEC)
            pix_reg <= 32'd0;
        if (state_reg == F_READ)
            y_reg <= y_sum[21:6];
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job pushed into a full queue");

    a_read_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_READ |=> state_reg == F_EXEC)
        else $error("line read not followed by execute");

    a_push_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> state_reg == F_EXEC && !s_tready)
        else $error("job pushed outside execute");

endmodule

// File: rtl/lkf_back.sv
// ----------------------------------------------------------------------------
// lkf_back
// Kernel sum, chroma rebuild and clamp; three stages to the output register.
// ----------------------------------------------------------------------------
module lkf_back
    import lkf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lkf_job_t   head,
    input  lkf_qstat_t qstat,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [31:0] m_tdata,
    output logic       m_tlast
);

    logic               adv;
    logic               v1_reg, v2_reg, v3_reg;
    logic signed [23:0] s1_reg, u1_reg, vv1_reg;
    logic [15:0]        yc1_reg;
    logic [1:0]         mode1_reg;
    logic [7:0]         a1_reg, a2_reg, a3_reg;
    logic               l1_reg, l2_reg, l3_reg;
    logic signed [47:0] f2_reg, rv2_reg, gu2_reg, gv2_reg, bu2_reg;
    logic [7:0]         r3_reg, g3_reg, b3_reg;

    logic signed [23:0] s_sum, u_sum, v_sum;
    logic signed [47:0] f_val, r_sum, g_sum, b_sum;
    logic signed [5:0]  k;

    function automatic logic [7:0] to_byte(input logic signed [47:0] q);
        logic [7:0] res;
        if (q < 0)
            res = 8'd0;
        else if (q[47:36] != '0)
            res = 8'd255;
        else
            res = q[35:28];
        return res;
    endfunction

    assign adv = !v3_reg || m_tready;
    assign pop = adv && !qstat.empty;

    always_comb
    begin
        s_sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            case (head.mode)
                MODE_LAPLACIAN: k = KERN_LAP[i];
                MODE_SOBEL:     k = KERN_SOBEL[i];
                default:        k = KERN_SHARP[i];
            endcase
            s_sum = s_sum + 24'(k * $signed({1'b0, head.win[i]}));
        end
        u_sum = 24'(CU_R * int'(head.pix[7:0]) + CU_G * int'(head.pix[15:8])
                    + CU_B * int'(head.pix[23:16]));
        v_sum = 24'(CV_R * int'(head.pix[7:0]) + CV_G * int'(head.pix[15:8])
                    + CV_B * int'(head.pix[23:16]));
    end

    always_comb
    begin
        case (mode1_reg)
            MODE_LAPLACIAN: f_val = (48'(s1_reg) + 48'(yc1_reg)) <<< 20;
            MODE_SOBEL:     f_val = 48'(s1_reg) <<< 20;
            default:        f_val = (48'(s1_reg) * 48'(C_TENTH)) <<< 6;
        endcase
        r_sum = f2_reg + rv2_reg;
        g_sum = f2_reg - gu2_reg - gv2_reg;
        b_sum = f2_reg + bu2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= !qstat.empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg    <= s_sum;
            u1_reg    <= u_sum;
            vv1_reg   <= v_sum;
            yc1_reg   <= head.win[4];
            mode1_reg <= head.mode;
            a1_reg    <= head.pix[31:24];
            l1_reg    <= head.last;

            f2_reg  <= f_val;
            rv2_reg <= 48'(vv1_reg) * 48'(C_RV);
            gu2_reg <= 48'(u1_reg) * 48'(C_GU);
            gv2_reg <= 48'(vv1_reg) * 48'(C_GV);
            bu2_reg <= 48'(u1_reg) * 48'(C_BU);
            a2_reg  <= a1_reg;
            l2_reg  <= l1_reg;

            r3_reg <= to_byte(r_sum);
            g3_reg <= to_byte(g_sum);
            b3_reg <= to_byte(b_sum);
            a3_reg <= a2_reg;
            l3_reg <= l2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {a3_reg, b3_reg, g3_reg, r3_reg};
    assign m_tlast  = l3_reg;

endmodule

// File: rtl/luma_kernel_3x3_filter_top.sv
// ----------------------------------------------------------------------------
// luma_kernel_3x3_filter_top
// 3x3 luma kernel filter over a raster RGBA stream with two line buffers.
// ----------------------------------------------------------------------------
// Use: pixels enter on the s_ stream in raster order, one word per pixel,
// tuser low. Each result is the filtered pixel one row and one column back,
// so the frame's tail is drained by flush words (tuser high), one result per
// flush; flushes before the frame's last pixel are dropped. m_tlast marks
// the frame's last pixel. Registers (width, height, mode) are written on the
// cfg_ port while idle; writing width or height restarts the frame.
// Flow: each word passes the front's accept, line buffer read and update
// steps before the next is taken, because of the single-port line buffer
// read-modify-write; the first flush of a one-row frame repeats the read and
// update steps. Results leave through a 3-stage back pipeline after a
// 4-entry job queue. A stall on m_tready freezes the back; the front keeps
// taking words until the queue fills. Reset clears position, window and
// queue; line buffer contents are unknown but never used before written in
// a frame.
// ----------------------------------------------------------------------------
module luma_kernel_3x3_filter_top
    import lkf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // red_in, green_in, blue_in, alpha_in
    input  logic                  s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic                  m_tlast    // frame_last
);

    lkf_qstat_t qstat;
    lkf_job_t   push_job, head;
    logic       push, pop;

    lkf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .qstat     (qstat),
        .push      (push),
        .push_job  (push_job)
    );

    lkf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    lkf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
